// ===== rtl/mmpr_pkg.sv =====
// Shared types, constants and GF(2^8) helpers for the mix/MDS permutation round.
// Used by mmpr_lane, mmpr_mix and mix_mds_permutation_round; no dependencies.
package mmpr_pkg;

	localparam int unsigned LANES = 8;
	localparam int unsigned LANE_W = 64;
	localparam int unsigned HALF_W = LANE_W / 2;

	localparam logic [LANE_W-1:0] MUL_A = 64'hBF58476D1CE4E5B9;
	localparam logic [LANE_W-1:0] MUL_B = 64'h94D049BB133111EB;

	localparam logic [7:0] GF_REDUCE = 8'h1d;

	localparam logic [LANES-1:0][3:0] CIRC_COEF = {
		4'd9, 4'd2, 4'd5, 4'd8, 4'd1, 4'd4, 4'd1, 4'd1
	};

	typedef logic [LANES-1:0][LANE_W-1:0] lane_arr_t;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
	} lane_en_t;

	function automatic logic [7:0] gf_dbl(input logic [7:0] v);
		return {v[6:0], 1'b0} ^ (v[7] ? GF_REDUCE : 8'h00);
	endfunction

	function automatic logic [7:0] gf_scale(input logic [7:0] v, input logic [3:0] c);
		logic [7:0] acc;
		logic [7:0] pw;
		acc = 8'h00;
		pw = v;
		for (int b = 0; b < 4; b++) begin
			if (c[b]) begin
				acc = acc ^ pw;
			end
			pw = gf_dbl(pw);
		end
		return acc;
	endfunction

endpackage

// ===== rtl/mmpr_lane.sv =====
// One lane of the 64-bit finalizer, five stages, multiplies split into 32-bit partials.
// Depends on mmpr_pkg for constants and the stage enable struct.
module mmpr_lane (
	input  logic                           clk,
	input  mmpr_pkg::lane_en_t             en,
	input  logic [mmpr_pkg::LANE_W-1:0]    din,
	output logic [mmpr_pkg::LANE_W-1:0]    dout
);

	localparam logic [mmpr_pkg::HALF_W-1:0] A_LO = mmpr_pkg::MUL_A[mmpr_pkg::HALF_W-1:0];
	localparam logic [mmpr_pkg::HALF_W-1:0] A_HI =
		mmpr_pkg::MUL_A[mmpr_pkg::LANE_W-1:mmpr_pkg::HALF_W];
	localparam logic [mmpr_pkg::HALF_W-1:0] B_LO = mmpr_pkg::MUL_B[mmpr_pkg::HALF_W-1:0];
	localparam logic [mmpr_pkg::HALF_W-1:0] B_HI =
		mmpr_pkg::MUL_B[mmpr_pkg::LANE_W-1:mmpr_pkg::HALF_W];

	logic [mmpr_pkg::LANE_W-1:0] x_s1, x_s3, z_s5;
	logic [mmpr_pkg::LANE_W-1:0] ll_s2, ll_s4;
	logic [mmpr_pkg::HALF_W-1:0] hl_s2, lh_s2, hl_s4, lh_s4;
	logic [mmpr_pkg::LANE_W-1:0] ll_a, ll_b, y_a, y_b;
	logic [mmpr_pkg::HALF_W-1:0] hl_a, lh_a, hl_b, lh_b, cross_a, cross_b;

	assign ll_a = {{mmpr_pkg::HALF_W{1'b0}}, x_s1[mmpr_pkg::HALF_W-1:0]}
		* {{mmpr_pkg::HALF_W{1'b0}}, A_LO};
	assign hl_a = x_s1[mmpr_pkg::LANE_W-1:mmpr_pkg::HALF_W] * A_LO;
	assign lh_a = x_s1[mmpr_pkg::HALF_W-1:0] * A_HI;
	assign cross_a = hl_s2 + lh_s2;
	assign y_a = ll_s2 + {cross_a, {mmpr_pkg::HALF_W{1'b0}}};

	assign ll_b = {{mmpr_pkg::HALF_W{1'b0}}, x_s3[mmpr_pkg::HALF_W-1:0]}
		* {{mmpr_pkg::HALF_W{1'b0}}, B_LO};
	assign hl_b = x_s3[mmpr_pkg::LANE_W-1:mmpr_pkg::HALF_W] * B_LO;
	assign lh_b = x_s3[mmpr_pkg::HALF_W-1:0] * B_HI;
	assign cross_b = hl_s4 + lh_s4;
	assign y_b = ll_s4 + {cross_b, {mmpr_pkg::HALF_W{1'b0}}};

	always_ff @(posedge clk) begin
		if (en.s1) begin
			x_s1 <= din ^ (din >> 30);
		end
		if (en.s2) begin
			ll_s2 <= ll_a;
			hl_s2 <= hl_a;
			lh_s2 <= lh_a;
		end
		if (en.s3) begin
			x_s3 <= y_a ^ (y_a >> 27);
		end
		if (en.s4) begin
			ll_s4 <= ll_b;
			hl_s4 <= hl_b;
			lh_s4 <= lh_b;
		end
		if (en.s5) begin
			z_s5 <= y_b ^ (y_b >> 31);
		end
	end

	assign dout = z_s5;

endmodule

// ===== rtl/mmpr_mix.sv =====
// Byte-column MDS mixing over GF(2^8) with a registered output stage.
// Depends on mmpr_pkg for the circulant coefficients and GF helpers.
module mmpr_mix (
	input  logic                 clk,
	input  logic                 en,
	input  mmpr_pkg::lane_arr_t  mixed,
	output mmpr_pkg::lane_arr_t  result
);

	mmpr_pkg::lane_arr_t col_d;
	mmpr_pkg::lane_arr_t res_s6;

	always_comb begin
		logic [7:0] acc;
		logic [7:0] b;
		col_d = '0;
		for (int j = 0; j < mmpr_pkg::LANES; j++) begin
			for (int i = 0; i < mmpr_pkg::LANES; i++) begin
				acc = 8'h00;
				for (int k = 0; k < mmpr_pkg::LANES; k++) begin
					b = mixed[k][mmpr_pkg::LANE_W-1-8*j -: 8];
					acc = acc ^ mmpr_pkg::gf_scale(b, mmpr_pkg::CIRC_COEF[3'(i - k)]);
				end
				col_d[j][mmpr_pkg::LANE_W-1-8*i -: 8] = acc;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s6 <= col_d;
		end
	end

	assign result = res_s6;

endmodule

// ===== rtl/mix_mds_permutation_round.sv =====
// Top level of the mix/MDS permutation round: eight finalizer lanes and the column mixer.
// Depends on mmpr_pkg, mmpr_lane and mmpr_mix.
//
// Input channel: in_lane0..in_lane7 with in_valid / in_stall; a transfer happens at a
// rising edge with in_valid high and in_stall low.
// Output channel: out_lane0..out_lane7 with out_valid / out_stall, same rule.
// Each state goes through a six-stage pipeline: one stage for the first xor-shift,
// two stages per 64-bit multiply (32-bit partial products, then their sum and the
// next xor-shift), and one registered stage for the GF(2^8) column mix. out_valid
// rises once the state has passed stages s1 to s6 and sits in the mixer register;
// one state is taken every cycle while the output is not stalled.
// Each stage holds its own valid bit and advances when the stage after it is empty
// or moving, so bubbles close up while the receiver stalls and in_stall rises only
// once every stage is full. A stalled result holds on the output ports unchanged.
// Reset clears all valid bits; the pipeline is empty and accepts input at once.
module mix_mds_permutation_round (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [63:0] in_lane0,
	input  logic [63:0] in_lane1,
	input  logic [63:0] in_lane2,
	input  logic [63:0] in_lane3,
	input  logic [63:0] in_lane4,
	input  logic [63:0] in_lane5,
	input  logic [63:0] in_lane6,
	input  logic [63:0] in_lane7,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] out_lane0,
	output logic [63:0] out_lane1,
	output logic [63:0] out_lane2,
	output logic [63:0] out_lane3,
	output logic [63:0] out_lane4,
	output logic [63:0] out_lane5,
	output logic [63:0] out_lane6,
	output logic [63:0] out_lane7
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic adv1, adv2, adv3, adv4, adv5, adv6;
	mmpr_pkg::lane_en_t en;
	mmpr_pkg::lane_arr_t lanes_in, lanes_fin, lanes_out;

	assign adv6 = !v_s6 || !out_stall;
	assign adv5 = !v_s5 || adv6;
	assign adv4 = !v_s4 || adv5;
	assign adv3 = !v_s3 || adv4;
	assign adv2 = !v_s2 || adv3;
	assign adv1 = !v_s1 || adv2;

	assign in_stall = !adv1;
	assign out_valid = v_s6;

	assign en.s1 = adv1;
	assign en.s2 = adv2;
	assign en.s3 = adv3;
	assign en.s4 = adv4;
	assign en.s5 = adv5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= in_valid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
			if (adv4) v_s4 <= v_s3;
			if (adv5) v_s5 <= v_s4;
			if (adv6) v_s6 <= v_s5;
		end
	end

	assign lanes_in = {in_lane7, in_lane6, in_lane5, in_lane4,
		in_lane3, in_lane2, in_lane1, in_lane0};

	for (genvar g = 0; g < mmpr_pkg::LANES; g++) begin : g_lane
		mmpr_lane u_lane (
			.clk  (clk),
			.en   (en),
			.din  (lanes_in[g]),
			.dout (lanes_fin[g])
		);
	end

	mmpr_mix u_mix (
		.clk    (clk),
		.en     (adv6),
		.mixed  (lanes_fin),
		.result (lanes_out)
	);

	assign out_lane0 = lanes_out[0];
	assign out_lane1 = lanes_out[1];
	assign out_lane2 = lanes_out[2];
	assign out_lane3 = lanes_out[3];
	assign out_lane4 = lanes_out[4];
	assign out_lane5 = lanes_out[5];
	assign out_lane6 = lanes_out[6];
	assign out_lane7 = lanes_out[7];

	a_empty_out_takes_input: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s6 |-> !in_stall)
		else $error("input stalled while output stage empty");

	a_input_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> v_s1)
		else $error("accepted state missing from first stage");

	a_blocked_stage_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s5 && !adv6) |=> v_s5)
		else $error("blocked stage lost its item");

	a_stage_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s5 && adv6) |=> v_s6)
		else $error("item dropped between last finalizer stage and mixer");

endmodule
